// ===== rtl/off_cpu_interval_tracker_unit_defines.svh =====
// ============================================================================
// off_cpu_interval_tracker_unit_defines.svh
// Assertion macros shared by the off-processor interval tracker.
// ============================================================================
`ifndef OFF_CPU_INTERVAL_TRACKER_UNIT_DEFINES_SVH
`define OFF_CPU_INTERVAL_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define OCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define OCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/oct_pkg.sv =====
// ============================================================================
// oct_pkg
// Types, command codes and default sizes for the off-processor interval
// tracker.
// ============================================================================
`default_nettype none

package oct_pkg;

	// Default sizes
	localparam int THREAD_COUNT_DEF  = 65536;
	localparam int PROCESS_COUNT_DEF = 65536;
	localparam int TIME_BITS_DEF     = 64;

	// Command codes
	localparam logic [1:0] CMD_SWITCH = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	// Input transaction
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] prev_thread;
		logic [15:0] next_thread;
		logic [15:0] next_process;
		logic [63:0] now_time;
	} in_item_t;

	// Result transaction
	typedef struct packed {
		logic [15:0] process_id;
		logic [15:0] thread_id;
		logic [63:0] off_cpu_time;
		logic [63:0] event_time;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic sweep;   // clear one entry of the valid and tracked stores
		logic accept;  // capture the input transaction, first store access
		logic commit;  // retire the switch: clear entry, load result
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_done;  // last entry of the clearing pass
		logic result;      // current switch yields a result
		logic out_busy;    // output register full and stalled
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/oct_ctrl.sv =====
// ============================================================================
// oct_ctrl
// Controller: clearing pass after reset, accept, and lookup/commit phase.
// ============================================================================
`default_nettype none

module oct_ctrl
	import oct_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       sw_valid,
	input  wire logic [1:0] sw_cmd,
	output logic            sw_stall,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Command decode
	always_comb begin
		cmd.sweep  = (state_q == ST_CLEAR);
		cmd.accept = (state_q == ST_IDLE) && sw_valid;
		cmd.commit = (state_q == ST_LOOKUP) && !(status.result && status.out_busy);
	end

	assign sw_stall = (state_q != ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.sweep_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.accept && (sw_cmd == CMD_SWITCH)) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/oct_datapath.sv =====
// ============================================================================
// oct_datapath
// Start-time, valid and tracked-process stores, interval subtract and the
// output register.
// ============================================================================
`default_nettype none

module oct_datapath
	import oct_pkg::*;
#(
	parameter int THREAD_COUNT  = THREAD_COUNT_DEF,
	parameter int PROCESS_COUNT = PROCESS_COUNT_DEF,
	parameter int TIME_BITS     = TIME_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  sw_item,
	input  wire ctrl_cmd_t cmd,
	output dp_status_t     status,
	output logic           res_valid,
	input  wire logic      res_stall,
	output out_item_t      res_item
);

	localparam int TIDX_W    = $clog2(THREAD_COUNT);
	localparam int PIDX_W    = $clog2(PROCESS_COUNT);
	localparam int SWEEP_LEN = (THREAD_COUNT > PROCESS_COUNT) ? THREAD_COUNT : PROCESS_COUNT;
	localparam int CNT_W     = $clog2(SWEEP_LEN);

	// Stores
	logic [TIME_BITS-1:0] time_mem [THREAD_COUNT];
	logic                 vld_mem  [THREAD_COUNT];
	logic                 trk_mem  [PROCESS_COUNT];

	// Clearing pass counter
	logic [CNT_W-1:0] cnt_q;

	// Captured transaction and lookup data
	in_item_t             item_q;
	logic                 same_q;
	logic                 next_ok_q;
	logic                 proc_ok_q;
	logic                 vld_rd_q;
	logic                 trk_rd_q;
	logic [TIME_BITS-1:0] time_rd_q;

	// Output register
	out_item_t res_q;
	logic      res_valid_q;

	// Input decode
	logic              prev_ok;
	logic              next_ok;
	logic              proc_ok;
	logic              is_switch;
	logic              is_set;
	logic [TIDX_W-1:0] prev_idx;
	logic [TIDX_W-1:0] next_idx;
	logic [PIDX_W-1:0] proc_idx;
	logic [TIME_BITS-1:0] now_in;

	assign prev_ok   = (sw_item.prev_thread != 16'd0) &&
	                   (32'(sw_item.prev_thread) < 32'(THREAD_COUNT));
	assign next_ok   = (32'(sw_item.next_thread) < 32'(THREAD_COUNT));
	assign proc_ok   = (32'(sw_item.next_process) < 32'(PROCESS_COUNT));
	assign is_switch = (sw_item.cmd == CMD_SWITCH);
	assign is_set    = (sw_item.cmd == CMD_ADD) || (sw_item.cmd == CMD_REMOVE);
	assign prev_idx  = TIDX_W'(sw_item.prev_thread);
	assign next_idx  = TIDX_W'(sw_item.next_thread);
	assign proc_idx  = PIDX_W'(sw_item.next_process);
	assign now_in    = sw_item.now_time[TIME_BITS-1:0];

	// Lookup evaluation
	logic                 hit;
	logic                 result;
	logic [TIME_BITS-1:0] now_m;
	logic [TIME_BITS-1:0] start_t;
	logic [TIME_BITS-1:0] delta;
	logic [TIDX_W-1:0]    held_next_idx;

	assign now_m         = item_q.now_time[TIME_BITS-1:0];
	assign held_next_idx = TIDX_W'(item_q.next_thread);
	assign hit           = next_ok_q && (same_q || vld_rd_q);
	assign result        = hit && proc_ok_q && trk_rd_q;
	assign start_t       = same_q ? now_m : time_rd_q;
	assign delta         = now_m - start_t;

	// Valid store write port: sweep, outgoing thread, or read-clear
	logic              vld_we;
	logic [TIDX_W-1:0] vld_wa;
	logic              vld_wd;

	always_comb begin
		vld_we = 1'b0;
		vld_wa = prev_idx;
		vld_wd = 1'b1;
		priority if (cmd.sweep) begin
			vld_we = (32'(cnt_q) < 32'(THREAD_COUNT));
			vld_wa = TIDX_W'(cnt_q);
			vld_wd = 1'b0;
		end else if (cmd.accept) begin
			vld_we = is_switch && prev_ok;
		end else if (cmd.commit) begin
			vld_we = hit;
			vld_wa = held_next_idx;
			vld_wd = 1'b0;
		end
	end

	// Tracked store write port: sweep or add/remove
	logic              trk_we;
	logic [PIDX_W-1:0] trk_wa;
	logic              trk_wd;

	always_comb begin
		trk_we = 1'b0;
		trk_wa = proc_idx;
		trk_wd = (sw_item.cmd == CMD_ADD);
		priority if (cmd.sweep) begin
			trk_we = (32'(cnt_q) < 32'(PROCESS_COUNT));
			trk_wa = PIDX_W'(cnt_q);
			trk_wd = 1'b0;
		end else if (cmd.accept) begin
			trk_we = is_set && proc_ok;
		end
	end

	// Memories, registered reads at accept
	always_ff @(posedge clk) begin
		if (cmd.accept && is_switch && prev_ok) time_mem[prev_idx] <= now_in;
		if (cmd.accept) time_rd_q <= time_mem[next_idx];
	end

	always_ff @(posedge clk) begin
		if (vld_we) vld_mem[vld_wa] <= vld_wd;
		if (cmd.accept) vld_rd_q <= vld_mem[next_idx];
	end

	always_ff @(posedge clk) begin
		if (trk_we) trk_mem[trk_wa] <= trk_wd;
		if (cmd.accept) trk_rd_q <= trk_mem[proc_idx];
	end

	// Transaction capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q    <= sw_item;
			same_q    <= prev_ok && (sw_item.prev_thread == sw_item.next_thread);
			next_ok_q <= next_ok;
			proc_ok_q <= proc_ok;
		end
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.sweep) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit && result) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && result) begin
			res_q.process_id   <= item_q.next_process;
			res_q.thread_id    <= item_q.next_thread;
			res_q.off_cpu_time <= 64'(delta);
			res_q.event_time   <= 64'(now_m);
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Status
	assign status.sweep_done = (cnt_q == CNT_W'(SWEEP_LEN - 1));
	assign status.result     = result;
	assign status.out_busy   = res_valid_q && res_stall;

endmodule

`default_nettype wire

// ===== rtl/off_cpu_interval_tracker_unit.sv =====
// ============================================================================
// off_cpu_interval_tracker_unit
// Input channel sw_valid/sw_stall/sw_item: a context switch stores the time
// for the outgoing thread and, if the incoming thread has a stored time,
// clears it and measures the interval; add/remove commands edit the set of
// tracked processes. Result channel res_valid/res_stall/res_item carries
// one transaction per measured interval whose process is tracked.
// A switch is taken in the idle state, which captures the item and reads
// the stores; the lookup state then clears the entry, subtracts and loads
// the output register; it waits while a result meets a full, stalled
// output register. Add, remove and unused commands finish at accept. The
// valid store has one write port, used first for the outgoing thread and
// then to clear the incoming one, which sets the switch rate. After reset,
// a clearing pass over max(THREAD_COUNT, PROCESS_COUNT) entries (65536 by
// default) empties the valid and tracked stores; sw_stall is high during
// it. A stalled result holds the output register; the block takes the
// next item meanwhile and only waits if that item yields a result too.
// ============================================================================
`default_nettype none

`include "off_cpu_interval_tracker_unit_defines.svh"

module off_cpu_interval_tracker_unit
	import oct_pkg::*;
#(
	parameter int THREAD_COUNT  = THREAD_COUNT_DEF,
	parameter int PROCESS_COUNT = PROCESS_COUNT_DEF,
	parameter int TIME_BITS     = TIME_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     sw_valid,
	output logic          sw_stall,
	input  wire in_item_t sw_item,
	output logic          res_valid,
	input  wire logic     res_stall,
	output out_item_t     res_item
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	oct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sw_valid (sw_valid),
		.sw_cmd   (sw_item.cmd),
		.sw_stall (sw_stall),
		.status   (status),
		.cmd      (cmd)
	);

	oct_datapath #(
		.THREAD_COUNT  (THREAD_COUNT),
		.PROCESS_COUNT (PROCESS_COUNT),
		.TIME_BITS     (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.sw_item   (sw_item),
		.cmd       (cmd),
		.status    (status),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// Checks
	`OCT_ASSERT_NOW(a_sweep_stalls, cmd.sweep, sw_stall, "transaction taken during clearing pass")
	`OCT_ASSERT_NOW(a_no_accept_commit, cmd.accept, !cmd.commit, "accept and commit together")
	`OCT_ASSERT_NEXT(a_switch_lookup, cmd.accept && (sw_item.cmd == CMD_SWITCH), sw_stall, "no lookup")
	`OCT_ASSERT_NOW(a_result_from_commit, $rose(res_valid), $past(cmd.commit), "result without commit")

endmodule

`default_nettype wire
